// File: rtl/core/oss_pkg.sv
package oss_pkg;

    localparam int NUM_BUCKETS      = 8192;
    localparam int CELLS            = 2;
    localparam int DAYS             = 2;
    localparam int MAX_COUNTER_BITS = 16;

    localparam int ADDR_W = $clog2(NUM_BUCKETS);
    localparam int POS_W  = ADDR_W + 1;
    localparam int DAY_W  = 16;
    localparam int SUM_W  = 19;
    localparam int CIDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int Q_DEPTH = 2;
    localparam int Q_IDX_W = 1;

    localparam logic [31:0] HASH_MUL   = 32'd131;
    localparam logic [31:0] SEED_RESET = 32'd1337;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_TICK   = 2'd1;
    localparam logic [1:0] REQ_REPORT = 2'd2;

    localparam logic [2:0] CFG_SEED    = 3'd0;
    localparam logic [2:0] CFG_BUCKETS = 3'd1;
    localparam logic [2:0] CFG_THRESH  = 3'd2;
    localparam logic [2:0] CFG_CBITS   = 3'd3;
    localparam logic [2:0] CFG_RATE    = 3'd4;

    typedef logic [DAYS-1:0][DAY_W-1:0] t_days;

    typedef struct packed {
        logic [CELLS-1:0][31:0] key;
        logic [CELLS-1:0]       used;
        t_days [CELLS-1:0]      days;
        logic [CELLS-1:0]       on;
        t_days                  bdays;
        logic                   bon;
    } t_row;

    localparam t_row ROW_RESET = '{key: '0, used: '0, days: '0, on: '1, bdays: '0, bon: 1'b1};

    typedef struct packed {
        logic [31:0] seed;
        logic [13:0] buckets;
        logic [18:0] thresh;
        logic [4:0]  cbits;
        logic [31:0] rate;
    } t_cfg;

    typedef struct packed {
        logic [1:0]        op;
        logic [31:0]       flow_id;
        logic [ADDR_W-1:0] bucket;
    } t_cmd;

    function automatic logic [13:0] f_bucket_total(input logic [13:0] v);
        logic [13:0] m;
        m = v;
        if (m == 14'd0) m = 14'd1;
        if (m > 14'(NUM_BUCKETS)) m = 14'(NUM_BUCKETS);
        return m;
    endfunction

    function automatic logic [DAY_W-1:0] f_field_max(input logic [4:0] v);
        logic [4:0]  b;
        logic [16:0] one_hot;
        b = v;
        if (b == 5'd0) b = 5'd1;
        if (b > 5'(MAX_COUNTER_BITS)) b = 5'(MAX_COUNTER_BITS);
        one_hot = 17'd1 << b;
        return DAY_W'(one_hot - 17'd1);
    endfunction

    function automatic logic [SUM_W-1:0] f_day_sum(input t_days d);
        logic [SUM_W-1:0] s;
        s = '0;
        for (int i = 0; i < DAYS; i++) s = s + SUM_W'(d[i]);
        return s;
    endfunction

    function automatic t_days f_shift(input t_days d);
        t_days r;
        for (int i = DAYS - 1; i > 0; i--) r[i] = d[i-1];
        r[0] = '0;
        return r;
    endfunction

endpackage

// File: rtl/core/oss_front.sv
module oss_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [1:0]         i_req_type,
    input  logic [31:0]        i_flow_id,
    input  logic [12:0]        i_report_bucket,
    input  oss_pkg::t_cfg      i_cfg,
    input  logic               i_q_full,
    output logic               o_push,
    output oss_pkg::t_cmd      o_cmd,
    output logic               o_busy
);
    import oss_pkg::*;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_HASH = 4'b0010,
        F_MOD  = 4'b0100,
        F_PUSH = 4'b1000
    } t_fstate;

    t_fstate     r_state, n_state;
    t_cmd        r_cmd, n_cmd;
    logic [31:0] r_x, n_x;
    logic [1:0]  r_byte, n_byte;
    logic [2:0]  r_step, n_step;
    logic [ADDR_W-1:0] r_rem, n_rem;

    logic [13:0] m;
    logic [7:0]  hbyte;
    logic [13:0] t;

    assign m      = f_bucket_total(i_cfg.buckets);
    assign hbyte  = r_cmd.flow_id[{r_byte, 3'b000} +: 8];
    assign o_busy = (r_state != F_IDLE);
    assign o_cmd  = r_cmd;
    assign o_push = (r_state == F_PUSH) && !i_q_full;

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_x     = r_x;
        n_byte  = r_byte;
        n_step  = r_step;
        n_rem   = r_rem;
        t       = '0;
        case (r_state)
            F_IDLE: begin
                if (i_accept) begin
                    n_cmd.op      = i_req_type;
                    n_cmd.flow_id = i_flow_id;
                    n_cmd.bucket  = ADDR_W'(i_report_bucket);
                    case (i_req_type)
                        REQ_INSERT: begin
                            n_x     = i_cfg.seed;
                            n_byte  = 2'd0;
                            n_state = F_HASH;
                        end
                        REQ_TICK: n_state = F_PUSH;
                        REQ_REPORT: begin
                            if (14'(i_report_bucket) < m) n_state = F_PUSH;
                        end
                        default: n_state = F_IDLE;
                    endcase
                end
            end
            F_HASH: begin
                n_x    = r_x * HASH_MUL + 32'(hbyte);
                n_byte = r_byte + 2'd1;
                if (r_byte == 2'd3) begin
                    n_step  = 3'd0;
                    n_rem   = '0;
                    n_state = F_MOD;
                end
            end
            F_MOD: begin
                for (int i = 0; i < 4; i++) begin
                    t = {n_rem, n_x[31]};
                    if (t >= m) t = t - m;
                    n_rem = t[ADDR_W-1:0];
                    n_x   = {n_x[30:0], 1'b0};
                end
                n_step = r_step + 3'd1;
                if (r_step == 3'd7) begin
                    n_cmd.bucket = n_rem;
                    n_state      = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_q_full) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cmd  <= n_cmd;
        r_x    <= n_x;
        r_byte <= n_byte;
        r_step <= n_step;
        r_rem  <= n_rem;
    end

endmodule

// File: rtl/core/oss_fifo.sv
module oss_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  oss_pkg::t_cmd i_data,
    input  logic          i_pop,
    output oss_pkg::t_cmd o_data,
    output logic          o_full,
    output logic          o_empty
);
    import oss_pkg::*;

    t_cmd               r_q [Q_DEPTH];
    logic [Q_IDX_W-1:0] r_wp, r_rp;
    logic [Q_IDX_W:0]   r_cnt;

    assign o_data  = r_q[r_rp];
    assign o_full  = (r_cnt == (Q_IDX_W+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (i_pop && !i_push) r_cnt <= r_cnt - 1'b1;
        end
        if (i_push) r_q[r_wp] <= i_data;
    end

endmodule

// File: rtl/core/oss_back.sv
module oss_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  oss_pkg::t_cfg i_cfg,
    input  logic          i_q_empty,
    input  oss_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_clearing,
    output logic          o_valid,
    output logic [2:0]    o_cell_slot,
    output logic [31:0]   o_cell_key,
    output logic          o_cell_occupied,
    output logic [18:0]   o_cell_count,
    output logic          o_is_persistent,
    output logic          o_overflow_seen,
    output logic          o_last_cell
);
    import oss_pkg::*;

    typedef enum logic [9:0] {
        S_CLR     = 10'b0000000001,
        S_IDLE    = 10'b0000000010,
        S_INS_RD  = 10'b0000000100,
        S_INS_WR  = 10'b0000001000,
        S_RPT_RD  = 10'b0000010000,
        S_RPT_OUT = 10'b0000100000,
        S_ON_RD   = 10'b0001000000,
        S_ON_WR   = 10'b0010000000,
        S_SH_RD   = 10'b0100000000,
        S_SH_WR   = 10'b1000000000
    } t_bstate;

    t_row r_mem [NUM_BUCKETS];
    t_row r_rdata;

    t_bstate           r_state, n_state;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [31:0]       r_id, n_id;
    logic              r_ovf, n_ovf;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [15:0]       r_frac, n_frac;
    logic [16:0]       r_left, n_left;
    logic [CIDX_W-1:0] r_cell, n_cell;

    logic              r_valid, r_occ, r_pers, r_ovf_out, r_last;
    logic [2:0]        r_slot;
    logic [31:0]       r_key;
    logic [SUM_W-1:0]  r_count;

    logic              we, rd_en;
    logic [ADDR_W-1:0] wa, rd_addr, p;
    t_row              wd, ins_row;
    logic              ins_ovf;
    logic [13:0]       m;
    logic [DAY_W-1:0]  fmax;
    logic [32:0]       acc;
    logic              hit;
    logic [CIDX_W-1:0] hit_idx, best;
    logic [SUM_W-1:0]  best_sum, cur_sum, bsum, rpt_sum;
    t_days             tmp_days;
    logic              tmp_on;

    assign m          = f_bucket_total(i_cfg.buckets);
    assign fmax       = f_field_max(i_cfg.cbits);
    assign acc        = 33'(r_frac) + 33'(i_cfg.rate);
    assign p          = (r_pos >= POS_W'(m)) ? '0 : r_pos[ADDR_W-1:0];
    assign o_clearing = (r_state == S_CLR);
    assign rpt_sum    = f_day_sum(r_rdata.days[r_cell]);

    always_comb begin
        ins_row  = r_rdata;
        ins_ovf  = 1'b0;
        hit      = 1'b0;
        hit_idx  = '0;
        best     = '0;
        best_sum = '0;
        cur_sum  = '0;
        bsum     = '0;
        tmp_days = '0;
        tmp_on   = 1'b0;
        for (int c = 0; c < CELLS; c++) begin
            if (!hit && r_rdata.used[c] && r_rdata.key[c] == r_id) begin
                hit     = 1'b1;
                hit_idx = CIDX_W'(c);
            end
        end
        if (hit) begin
            if (r_rdata.on[hit_idx]) begin
                if (r_rdata.days[hit_idx][0] >= fmax) begin
                    ins_ovf = 1'b1;
                end else begin
                    ins_row.days[hit_idx][0] = r_rdata.days[hit_idx][0] + 1'b1;
                end
                ins_row.on[hit_idx] = 1'b0;
            end
        end else begin
            if (r_rdata.bon) begin
                if (r_rdata.bdays[0] >= fmax) begin
                    ins_ovf = 1'b1;
                end else begin
                    ins_row.bdays[0] = r_rdata.bdays[0] + 1'b1;
                end
                ins_row.bon = 1'b0;
            end
            for (int c = 0; c < CELLS; c++) begin
                cur_sum = f_day_sum(r_rdata.days[c]);
                if (c == 0 || cur_sum < best_sum) begin
                    best     = CIDX_W'(c);
                    best_sum = cur_sum;
                end
            end
            bsum = f_day_sum(ins_row.bdays);
            if (bsum > best_sum) begin
                tmp_days             = ins_row.bdays;
                tmp_on               = ins_row.bon;
                ins_row.key[best]    = r_id;
                ins_row.used[best]   = 1'b1;
                ins_row.bdays        = r_rdata.days[best];
                ins_row.bon          = r_rdata.on[best];
                ins_row.days[best]   = tmp_days;
                ins_row.on[best]     = tmp_on;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        n_id    = r_id;
        n_ovf   = r_ovf;
        n_pos   = r_pos;
        n_frac  = r_frac;
        n_left  = r_left;
        n_cell  = r_cell;
        o_pop   = 1'b0;
        we      = 1'b0;
        wa      = r_addr;
        wd      = r_rdata;
        rd_en   = 1'b0;
        rd_addr = r_addr;
        case (r_state)
            S_CLR: begin
                we     = 1'b1;
                wd     = ROW_RESET;
                n_addr = r_addr + 1'b1;
                if (r_addr == ADDR_W'(NUM_BUCKETS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop  = 1'b1;
                    n_addr = i_cmd.bucket;
                    n_id   = i_cmd.flow_id;
                    case (i_cmd.op)
                        REQ_INSERT: n_state = S_INS_RD;
                        REQ_REPORT: begin
                            n_cell  = '0;
                            n_state = S_RPT_RD;
                        end
                        REQ_TICK: begin
                            n_addr  = '0;
                            n_frac  = acc[15:0];
                            n_left  = acc[32:16];
                            n_state = S_ON_RD;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_INS_RD: begin
                rd_en   = 1'b1;
                n_state = S_INS_WR;
            end
            S_INS_WR: begin
                we      = 1'b1;
                wd      = ins_row;
                n_ovf   = r_ovf | ins_ovf;
                n_state = S_IDLE;
            end
            S_RPT_RD: begin
                rd_en   = 1'b1;
                n_state = S_RPT_OUT;
            end
            S_RPT_OUT: begin
                n_cell = r_cell + 1'b1;
                if (r_cell == CIDX_W'(CELLS - 1)) n_state = S_IDLE;
            end
            S_ON_RD: begin
                rd_en   = 1'b1;
                n_state = S_ON_WR;
            end
            S_ON_WR: begin
                we     = 1'b1;
                wd     = r_rdata;
                wd.on  = '1;
                wd.bon = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == ADDR_W'(NUM_BUCKETS - 1)) begin
                    n_state = (r_left == '0) ? S_IDLE : S_SH_RD;
                end else begin
                    n_state = S_ON_RD;
                end
            end
            S_SH_RD: begin
                rd_en   = 1'b1;
                rd_addr = p;
                n_addr  = p;
                n_pos   = POS_W'(p) + 1'b1;
                n_state = S_SH_WR;
            end
            S_SH_WR: begin
                we       = 1'b1;
                wd       = r_rdata;
                wd.bdays = f_shift(r_rdata.bdays);
                for (int c = 0; c < CELLS; c++) wd.days[c] = f_shift(r_rdata.days[c]);
                n_left   = r_left - 1'b1;
                n_state  = (r_left == 17'd1) ? S_IDLE : S_SH_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        if (rd_en) r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_addr  <= '0;
            r_ovf   <= 1'b0;
            r_pos   <= '0;
            r_frac  <= '0;
            r_left  <= '0;
            r_cell  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_ovf   <= n_ovf;
            r_pos   <= n_pos;
            r_frac  <= n_frac;
            r_left  <= n_left;
            r_cell  <= n_cell;
            r_valid <= (r_state == S_RPT_OUT);
        end
        r_id      <= n_id;
        r_slot    <= 3'(r_cell);
        r_key     <= r_rdata.key[r_cell];
        r_occ     <= r_rdata.used[r_cell];
        r_count   <= rpt_sum;
        r_pers    <= r_rdata.used[r_cell] && (rpt_sum >= i_cfg.thresh);
        r_ovf_out <= r_ovf;
        r_last    <= (r_cell == CIDX_W'(CELLS - 1));
    end

    assign o_valid         = r_valid;
    assign o_cell_slot     = r_slot;
    assign o_cell_key      = r_key;
    assign o_cell_occupied = r_occ;
    assign o_cell_count    = r_count;
    assign o_is_persistent = r_pers;
    assign o_overflow_seen = r_ovf_out;
    assign o_last_cell     = r_last;

endmodule

// File: rtl/core/onoff_sliding_persistence_sketch_top.sv
// On-off sliding sketch for persistent flows.
// Command channel: a transaction is taken at a clock edge with start high and busy
// low; i_req_type selects packet insert, window tick or bucket report.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index at once.
// Result channel: o_valid marks each report line for one cycle; o_last_cell
// marks the final one. The receiver cannot stall, results are never held.
// The front hashes the flow id byte by byte and reduces it modulo the bucket
// count in a 4-bits-per-cycle remainder unit, then queues it; busy stays
// high until the command is queued, so the next transaction waits for that
// and for room in the two-entry queue; a report for a bucket at or beyond
// the bucket count is dropped. The queue lets the back run on its own.
// The back uses the single-port bucket memory: an insert reads its row and
// writes it back, a report reads its row and then emits its cells from an
// output register, one cell per cycle. A tick walks the whole memory to
// re-arm on flags, reading and writing back each bucket, and then shifts
// its quota of buckets the same way.
// After reset the back clears all 8192 bucket rows, one per cycle; busy stays
// high while they are cleared, configuration writes are taken meanwhile.
module onoff_sliding_persistence_sketch_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_flow_id,
    input  logic [12:0] i_report_bucket,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    output logic [2:0]  o_cell_slot,
    output logic [31:0] o_cell_key,
    output logic        o_cell_occupied,
    output logic [18:0] o_cell_count,
    output logic        o_is_persistent,
    output logic        o_overflow_seen,
    output logic        o_last_cell
);
    import oss_pkg::*;

    t_cfg r_cfg;
    t_cmd push_cmd, head_cmd;
    logic push, pop, q_full, q_empty, front_busy, clearing;

    assign busy = front_busy | clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seed    <= SEED_RESET;
            r_cfg.buckets <= 14'd844;
            r_cfg.thresh  <= 19'd12;
            r_cfg.cbits   <= 5'd5;
            r_cfg.rate    <= 32'd3457024;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SEED:    r_cfg.seed    <= i_cfg_data;
                CFG_BUCKETS: r_cfg.buckets <= i_cfg_data[13:0];
                CFG_THRESH:  r_cfg.thresh  <= i_cfg_data[18:0];
                CFG_CBITS:   r_cfg.cbits   <= i_cfg_data[4:0];
                CFG_RATE:    r_cfg.rate    <= i_cfg_data;
                default:     r_cfg         <= r_cfg;
            endcase
        end
    end

    oss_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (start && !busy),
        .i_req_type     (i_req_type),
        .i_flow_id      (i_flow_id),
        .i_report_bucket(i_report_bucket),
        .i_cfg          (r_cfg),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_cmd          (push_cmd),
        .o_busy         (front_busy)
    );

    oss_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (push_cmd),
        .i_pop  (pop),
        .o_data (head_cmd),
        .o_full (q_full),
        .o_empty(q_empty)
    );

    oss_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_empty      (q_empty),
        .i_cmd          (head_cmd),
        .o_pop          (pop),
        .o_clearing     (clearing),
        .o_valid        (o_valid),
        .o_cell_slot    (o_cell_slot),
        .o_cell_key     (o_cell_key),
        .o_cell_occupied(o_cell_occupied),
        .o_cell_count   (o_cell_count),
        .o_is_persistent(o_is_persistent),
        .o_overflow_seen(o_overflow_seen),
        .o_last_cell    (o_last_cell)
    );

endmodule
